// ===== hw/rtl/pwn_pkg.sv =====
// Shared constants, codes and types of the protein word neighborhood block.
package pwn_pkg;

	localparam int MAX_WORD      = 4;
	localparam int ALPHABET_SIZE = 20;
	localparam int DIGIT_BITS    = 5;
	localparam int WORD_BITS     = MAX_WORD * DIGIT_BITS;
	localparam int NBR_WORD_BITS = 20;
	localparam int TABLE_DEPTH   = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
	localparam int POS_BITS      = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int LEN_BITS      = 3;
	localparam int FILL_BITS     = $clog2(MAX_WORD + 1);
	localparam int ENTRY_BITS    = 5;
	localparam int THR_BITS      = 7;
	localparam int SUM_BITS      = $clog2(MAX_WORD * 16) + 2;

	// Opcodes of an input item
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_PUSH = 2'd1;
	localparam logic [1:0] OP_NEXT = 2'd2;

	// Result status codes
	localparam logic [1:0] RES_FOUND     = 2'd0;
	localparam logic [1:0] RES_EXHAUSTED = 2'd1;
	localparam logic [1:0] RES_NOT_FULL  = 2'd2;
	localparam logic [1:0] RES_ACK       = 2'd3;

	// Configuration port
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic REG_WORD_LENGTH = 1'b0;
	localparam logic REG_MIN_SCORE   = 1'b1;

	localparam logic [LEN_BITS-1:0] WORD_LENGTH_RST = LEN_BITS'(3);
	localparam logic [THR_BITS-1:0] THRESHOLD_RST   = THR_BITS'(11);

	typedef logic [MAX_WORD-1:0][DIGIT_BITS-1:0] word_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]        word_length;
		logic signed [THR_BITS-1:0] min_score;
	} cfg_t;

endpackage

// ===== hw/rtl/pwn_cfg_regs.sv =====
// APB register file: word length and score threshold.
module pwn_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pwn_pkg::PADDR_BITS-1:0]      paddr,
	input  logic [pwn_pkg::PDATA_BITS-1:0]      pwdata,
	output logic [pwn_pkg::PDATA_BITS-1:0]      prdata,
	output logic                                pready,
	output pwn_pkg::cfg_t                       cfg
);

	logic [pwn_pkg::LEN_BITS-1:0] word_length_q;
	logic [pwn_pkg::THR_BITS-1:0] threshold_q;
	logic                         reg_sel;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q <= pwn_pkg::WORD_LENGTH_RST;
			threshold_q   <= pwn_pkg::THRESHOLD_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				pwn_pkg::REG_WORD_LENGTH: word_length_q <= pwdata[pwn_pkg::LEN_BITS-1:0];
				pwn_pkg::REG_MIN_SCORE:   threshold_q   <= pwdata[pwn_pkg::THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			pwn_pkg::REG_WORD_LENGTH:
				prdata = pwn_pkg::PDATA_BITS'(word_length_q);
			pwn_pkg::REG_MIN_SCORE:
				prdata = pwn_pkg::PDATA_BITS'(threshold_q);
			default:
				prdata = '0;
		endcase
	end

	assign cfg.word_length = word_length_q;
	assign cfg.min_score   = $signed(threshold_q);

endmodule

// ===== hw/rtl/protein_word_neighborhood.sv =====
// Top level: score table memory, query window and neighbor word scan sequencer.
//
//   channel   direction  handshake             payload
//   -------   ---------  --------------------  ---------------------------------------------
//   in        sink       in_valid / in_stall   opcode, residue_a, residue_b, entry_score
//   out       source     out_valid / out_stall status, neighbor_word, neighbor_score
//   apb       slave      psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// Loads, pushes and requests that end at once (window not full, window exhausted)
// answer without a scan. A request that scans examines n candidates (n up to 20^L):
// the single read port of the score table gives one entry per cycle, L reads per
// candidate, then a step that compares and advances.
// Reset clears the window, fill count, candidate, done flag and output valid flag, and
// restores word_length 3 and threshold 11. The table needs no clearing pass.
// A result held by out_stall blocks the next transfer on the input side only.
module protein_word_neighborhood (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             opcode,
	input  logic [pwn_pkg::DIGIT_BITS-1:0]         residue_a,
	input  logic [pwn_pkg::DIGIT_BITS-1:0]         residue_b,
	input  logic signed [pwn_pkg::ENTRY_BITS-1:0]  entry_score,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [1:0]                             status,
	output logic [pwn_pkg::NBR_WORD_BITS-1:0]      neighbor_word,
	output logic signed [pwn_pkg::THR_BITS-1:0]    neighbor_score,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [pwn_pkg::PADDR_BITS-1:0]         paddr,
	input  logic [pwn_pkg::PDATA_BITS-1:0]         pwdata,
	output logic [pwn_pkg::PDATA_BITS-1:0]         prdata,
	output logic                                   pready
);

	localparam int SB = pwn_pkg::SUM_BITS;
	localparam int TB = pwn_pkg::THR_BITS;
	localparam int EB = pwn_pkg::ENTRY_BITS;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_EVAL  = 2'd2;

	localparam logic signed [SB-1:0] SAT_HI = SB'(2 ** (TB - 1) - 1);
	localparam logic signed [SB-1:0] SAT_LO = SB'(-(2 ** (TB - 1)));

	pwn_pkg::cfg_t cfg;

	pwn_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Score table: synchronous, with a write port for loads and a read port for the scan
	logic [EB-1:0] table_mem [pwn_pkg::TABLE_DEPTH];
	logic                           tbl_we;
	logic                           tbl_re;
	logic [pwn_pkg::ADDR_BITS-1:0]  tbl_waddr;
	logic [pwn_pkg::ADDR_BITS-1:0]  tbl_raddr;
	logic [EB-1:0]                  rd_data_s1;

	// Control and scan state
	logic [1:0]                     state_q;
	logic [pwn_pkg::DIGIT_BITS-1:0] win_q [pwn_pkg::MAX_WORD];
	logic [pwn_pkg::FILL_BITS-1:0]  fill_q;
	pwn_pkg::word_t                 cand_q;
	logic                           done_q;
	pwn_pkg::word_t                 w_q;
	logic [pwn_pkg::POS_BITS-1:0]   k_q;
	logic [pwn_pkg::LEN_BITS-1:0]   len_q;
	logic                           rd_vld_s1;
	logic signed [SB-1:0]           acc_q;

	// Output register
	logic                           out_valid_q;
	logic [1:0]                     status_q;
	pwn_pkg::word_t                 word_q;
	logic signed [TB-1:0]           score_q;

	logic                           accept;
	logic                           scan_start;
	logic                           res_set;
	logic [pwn_pkg::LEN_BITS-1:0]   eff_len;
	pwn_pkg::word_t                 cand_masked;
	pwn_pkg::word_t                 w_next;
	logic                           more;
	logic signed [SB-1:0]           rd_ext;
	logic signed [SB-1:0]           sum;
	logic signed [SB-1:0]           thr_ext;
	logic                           pass;
	logic signed [SB-1:0]           sum_sat;
	logic [pwn_pkg::DIGIT_BITS-1:0] q_res;
	logic [pwn_pkg::DIGIT_BITS-1:0] w_res;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	// A request with a full window and candidates left starts a scan; every
	// other transfer answers at once. A scan answers on a pass or on the wrap.
	assign scan_start = accept && (opcode == pwn_pkg::OP_NEXT)
	                    && (fill_q >= pwn_pkg::FILL_BITS'(eff_len)) && !done_q;
	assign res_set    = (accept && !scan_start) || ((state_q == S_EVAL) && (pass || !more));

	// Clamp the word length into 1..MAX_WORD
	always_comb begin
		if (cfg.word_length == '0)
			eff_len = pwn_pkg::LEN_BITS'(1);
		else if (cfg.word_length > pwn_pkg::LEN_BITS'(pwn_pkg::MAX_WORD))
			eff_len = pwn_pkg::LEN_BITS'(pwn_pkg::MAX_WORD);
		else
			eff_len = cfg.word_length;
	end

	// Keep only the low digits that the current length uses
	always_comb begin
		for (int k = 0; k < pwn_pkg::MAX_WORD; k++)
			cand_masked[k] = (pwn_pkg::LEN_BITS'(k) < eff_len) ? cand_q[k] : '0;
	end

	// Alphabetical successor: base-ALPHABET_SIZE increment over len_q digits
	always_comb begin
		logic carry;
		carry  = 1'b1;
		w_next = w_q;
		for (int k = 0; k < pwn_pkg::MAX_WORD; k++) begin
			if ((pwn_pkg::LEN_BITS'(k) < len_q) && carry) begin
				if (32'(w_q[k]) + 32'd1 < 32'(pwn_pkg::ALPHABET_SIZE)) begin
					w_next[k] = w_q[k] + 1'b1;
					carry     = 1'b0;
				end else begin
					w_next[k] = '0;
				end
			end
		end
		more = !carry;
	end

	// Table addressing: row is the query residue, column the candidate residue
	assign q_res     = win_q[pwn_pkg::POS_BITS'(pwn_pkg::MAX_WORD - 1) - k_q];
	assign w_res     = w_q[k_q];
	assign tbl_raddr = pwn_pkg::ADDR_BITS'(q_res) * pwn_pkg::ADDR_BITS'(pwn_pkg::ALPHABET_SIZE)
	                   + pwn_pkg::ADDR_BITS'(w_res);
	assign tbl_waddr = pwn_pkg::ADDR_BITS'(residue_a) * pwn_pkg::ADDR_BITS'(pwn_pkg::ALPHABET_SIZE)
	                   + pwn_pkg::ADDR_BITS'(residue_b);
	assign tbl_we    = accept && (opcode == pwn_pkg::OP_LOAD)
	                   && (32'(residue_a) < 32'(pwn_pkg::ALPHABET_SIZE))
	                   && (32'(residue_b) < 32'(pwn_pkg::ALPHABET_SIZE));
	assign tbl_re    = (state_q == S_ISSUE);

	always_ff @(posedge clk) begin
		if (tbl_we)
			table_mem[tbl_waddr] <= entry_score;
		if (tbl_re)
			rd_data_s1 <= table_mem[tbl_raddr];
	end

	// Sum of the entries read so far plus the one arriving now
	assign rd_ext  = $signed({{(SB - EB){rd_data_s1[EB-1]}}, rd_data_s1});
	assign sum     = acc_q + rd_ext;
	assign thr_ext = $signed({{(SB - TB){cfg.min_score[TB-1]}}, cfg.min_score});
	assign pass    = (sum >= thr_ext);

	always_comb begin
		if (sum > SAT_HI)
			sum_sat = SAT_HI;
		else if (sum < SAT_LO)
			sum_sat = SAT_LO;
		else
			sum_sat = sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cand_q      <= '0;
			done_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < pwn_pkg::MAX_WORD; i++)
				win_q[i] <= '0;
		end else begin
			rd_vld_s1 <= tbl_re;

			// Load a new result, or drop the old one once the consumer takes it
			if (res_set)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (scan_start) begin
						// Start the scan at the saved candidate
						state_q <= S_ISSUE;
					end
					if (accept && opcode == pwn_pkg::OP_PUSH
					    && 32'(residue_a) < 32'(pwn_pkg::ALPHABET_SIZE)) begin
						for (int i = 0; i < pwn_pkg::MAX_WORD - 1; i++)
							win_q[i] <= win_q[i+1];
						win_q[pwn_pkg::MAX_WORD-1] <= residue_a;
						if (fill_q < pwn_pkg::FILL_BITS'(pwn_pkg::MAX_WORD))
							fill_q <= fill_q + 1'b1;
						cand_q <= '0;
						done_q <= 1'b0;
					end
				end
				S_ISSUE: begin
					if (k_q == '0)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (pass) begin
						cand_q  <= w_next;
						done_q  <= !more;
						state_q <= S_IDLE;
					end else if (!more) begin
						cand_q  <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ISSUE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Scan datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w_q   <= cand_masked;
				len_q <= eff_len;
				k_q   <= pwn_pkg::POS_BITS'(eff_len - 1'b1);
				acc_q <= '0;
				if (accept) begin
					word_q  <= '0;
					score_q <= '0;
					if (opcode != pwn_pkg::OP_NEXT)
						status_q <= pwn_pkg::RES_ACK;
					else if (fill_q < pwn_pkg::FILL_BITS'(eff_len))
						status_q <= pwn_pkg::RES_NOT_FULL;
					else
						status_q <= pwn_pkg::RES_EXHAUSTED;
				end
			end
			S_ISSUE: begin
				if (rd_vld_s1)
					acc_q <= sum;
				if (k_q != '0)
					k_q <= k_q - 1'b1;
			end
			S_EVAL: begin
				acc_q <= '0;
				k_q   <= pwn_pkg::POS_BITS'(len_q - 1'b1);
				w_q   <= w_next;
				if (pass) begin
					status_q <= pwn_pkg::RES_FOUND;
					word_q   <= w_q;
					score_q  <= sum_sat[TB-1:0];
				end else begin
					status_q <= pwn_pkg::RES_EXHAUSTED;
					word_q   <= '0;
					score_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign neighbor_word  = pwn_pkg::NBR_WORD_BITS'(word_q);
	assign neighbor_score = score_q;

endmodule

// ===== tb/protein_word_neighborhood_test.sv =====
// Self-checking testbench of the protein word neighborhood block.
`timescale 1ns / 1ps

module protein_word_neighborhood_test;
	import pwn_pkg::*;

	// Opcode the block leaves unused: it only acknowledges.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [PADDR_BITS-1:0] ADDR_WORD_LENGTH = PADDR_BITS'(4 * REG_WORD_LENGTH);
	localparam logic [PADDR_BITS-1:0] ADDR_THRESHOLD   = PADDR_BITS'(4 * REG_MIN_SCORE);

	localparam logic signed [ENTRY_BITS-1:0] ENTRY_MIN = ENTRY_BITS'(-16);
	localparam logic signed [ENTRY_BITS-1:0] ENTRY_MAX = ENTRY_BITS'(15);
	localparam int SCORE_HI = 63;
	localparam int SCORE_LO = -64;

	// Longest legal scan is a full 3-residue walk (8000 candidates);
	// 4-residue words only run with the lowest threshold, so every word passes.
	localparam int STALL_LIMIT     = 150000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TAIL_CYCLES     = 50;
	localparam int MAX_PRINTED     = 40;

	// Configuration per phase: word length, threshold, item count.
	localparam int NUM_PHASES = 11;
	localparam int HOLD_PHASE = 1;
	int phase_len   [NUM_PHASES] = '{3, 1, 0, 2, 2, 1, 4, 7, 3, 2, 1};
	int phase_thr   [NUM_PHASES] = '{11, 0, -64, 63, 5, 63, -64, -64, 20, -10, 3};
	int phase_items [NUM_PHASES] = '{30, 30, 25, 20, 35, 20, 15, 10, 25, 35, 40};

	typedef struct packed {
		logic [1:0]                 status;
		logic [NBR_WORD_BITS-1:0]   word;
		logic signed [THR_BITS-1:0] score;
	} neighbor_result_t;

	// Scoreboard: mirrors table, window and scan position, and holds the results
	// still owed by the block, oldest first.
	class neighbor_scoreboard;
		logic signed [ENTRY_BITS-1:0] subst [TABLE_DEPTH];
		logic [DIGIT_BITS-1:0]        window [MAX_WORD];
		int unsigned                  fill;
		int unsigned                  cand;
		bit                           done;
		logic [LEN_BITS-1:0]          word_len;
		logic signed [THR_BITS-1:0]   threshold;
		neighbor_result_t             awaited [$];
		int                           errors;

		function new();
			foreach (subst[i]) subst[i] = '0;
			foreach (window[i]) window[i] = '0;
			fill = 0;
			cand = 0;
			done = 1'b0;
			word_len = WORD_LENGTH_RST;
			threshold = THRESHOLD_RST;
			errors = 0;
		endfunction

		function int word_score(int unsigned w, int unsigned len);
			int sum;
			int unsigned q, d;
			sum = 0;
			for (int unsigned j = 0; j < len; j++) begin
				q = window[MAX_WORD - len + j];
				d = (w >> ((len - 1 - j) * DIGIT_BITS)) & 31;
				sum += subst[q * ALPHABET_SIZE + d];
			end
			return sum;
		endfunction

		// Count up in base ALPHABET_SIZE over the low len digits; 0 on wrap.
		function bit step_word(inout int unsigned w, input int unsigned len);
			int unsigned d;
			for (int unsigned p = 0; p < len; p++) begin
				d = (w >> (p * DIGIT_BITS)) & 31;
				w &= ~(32'd31 << (p * DIGIT_BITS));
				if (d + 1 < ALPHABET_SIZE) begin
					w |= (d + 1) << (p * DIGIT_BITS);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function neighbor_result_t next_neighbor();
			neighbor_result_t r;
			int unsigned len, w, cur;
			int s;
			bit more, searching;
			len = (word_len == 0) ? 1 : (word_len > MAX_WORD) ? MAX_WORD : word_len;
			r = '0;
			if (fill < len) begin
				r.status = RES_NOT_FULL;
			end else if (done) begin
				r.status = RES_EXHAUSTED;
			end else begin
				r.status = RES_EXHAUSTED;
				w = cand & ((1 << (len * DIGIT_BITS)) - 1);
				searching = 1'b1;
				while (searching) begin
					s = word_score(w, len);
					cur = w;
					more = step_word(w, len);
					if (s >= int'(threshold)) begin
						r.status = RES_FOUND;
						r.word = NBR_WORD_BITS'(cur);
						r.score = THR_BITS'((s > SCORE_HI) ? SCORE_HI :
							(s < SCORE_LO) ? SCORE_LO : s);
						cand = w;
						done = !more;
						searching = 1'b0;
					end else if (!more) begin
						done = 1'b1;
						cand = 0;
						searching = 1'b0;
					end
				end
			end
			return r;
		endfunction

		function void note_item(logic [1:0] op, logic [DIGIT_BITS-1:0] a,
				logic [DIGIT_BITS-1:0] b, logic signed [ENTRY_BITS-1:0] e);
			neighbor_result_t r;
			r = '0;
			r.status = RES_ACK;
			case (op)
				OP_LOAD: begin
					if (a < ALPHABET_SIZE && b < ALPHABET_SIZE)
						subst[a * ALPHABET_SIZE + b] = e;
				end
				OP_PUSH: begin
					if (a < ALPHABET_SIZE) begin
						for (int i = 0; i < MAX_WORD - 1; i++) window[i] = window[i + 1];
						window[MAX_WORD - 1] = a;
						if (fill < MAX_WORD) fill++;
						cand = 0;
						done = 1'b0;
					end
				end
				OP_NEXT: r = next_neighbor();
				default: ;
			endcase
			awaited = {awaited, r};
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
		endtask

		task check_result(logic [1:0] st, logic [NBR_WORD_BITS-1:0] w,
				logic signed [THR_BITS-1:0] s);
			neighbor_result_t x;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result status %0d word %h score %0d", st, w, s));
				return;
			end
			x = awaited.pop_front();
			if (st !== x.status || w !== x.word || s !== x.score)
				report($sformatf("status %0d/%0d word %h/%h score %0d/%0d (got/want)",
					st, x.status, w, x.word, s, x.score));
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [1:0]                   opcode;
	logic [DIGIT_BITS-1:0]        residue_a;
	logic [DIGIT_BITS-1:0]        residue_b;
	logic signed [ENTRY_BITS-1:0] entry_score;
	logic                         out_valid;
	logic                         out_stall;
	logic [1:0]                   status;
	logic [NBR_WORD_BITS-1:0]     neighbor_word;
	logic signed [THR_BITS-1:0]   neighbor_score;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [PADDR_BITS-1:0]        paddr;
	logic [PDATA_BITS-1:0]        pwdata;
	logic [PDATA_BITS-1:0]        prdata;
	logic                         pready;

	neighbor_scoreboard sb = new();

	// Stimulus bookkeeping: which table entries hold a written score.
	bit          loaded [ALPHABET_SIZE][ALPHABET_SIZE];
	int unsigned items_sent = 0;
	bit          no_idling = 1'b0;
	bit          hold_off_req = 1'b0;

	protein_word_neighborhood u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.residue_a      (residue_a),
		.residue_b      (residue_b),
		.entry_score    (entry_score),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.neighbor_word  (neighbor_word),
		.neighbor_score (neighbor_score),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample both channels at the rising edge; retire results before noting the
	// new transfer so a result never meets its own expectation out of order.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(status, neighbor_word, neighbor_score);
		if (in_valid === 1'b1 && in_stall === 1'b0)
			sb.note_item(opcode, residue_a, residue_b, entry_score);
	end

	// Abort when no transfer of any kind happens for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result side back-pressure: random stall bursts, plus one long hold-off on
	// request so the block fills up and stalls its input.
	initial begin : result_stall
		int unsigned burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!no_idling && $urandom_range(0, 11) == 0) begin
				burst = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one item from a falling edge and hold it until the transfer. Leave
	// valid high afterwards: the next call either reuses it or drops it.
	task automatic send_item(input logic [1:0] op, input logic [DIGIT_BITS-1:0] a,
			input logic [DIGIT_BITS-1:0] b, input logic signed [ENTRY_BITS-1:0] e);
		int unsigned gap;
		if (!no_idling && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode <= op;
		residue_a <= a;
		residue_b <= b;
		entry_score <= e;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		// count only items the block acts on
		if (op == OP_NEXT || (op == OP_PUSH && a < ALPHABET_SIZE) ||
				(op == OP_LOAD && a < ALPHABET_SIZE && b < ALPHABET_SIZE))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [DIGIT_BITS-1:0] a, input logic [DIGIT_BITS-1:0] b,
			input logic signed [ENTRY_BITS-1:0] e);
		loaded[a][b] = 1'b1;
		send_item(OP_LOAD, a, b, e);
	endtask

	// Push a residue, mostly one whose row is already complete. Complete the
	// row first otherwise: a scan reads every column of each window residue.
	task automatic push_residue();
		int unsigned ready_rows [$];
		int unsigned r;
		bit complete;
		for (int unsigned i = 0; i < ALPHABET_SIZE; i++) begin
			complete = 1'b1;
			for (int unsigned j = 0; j < ALPHABET_SIZE; j++)
				if (!loaded[i][j]) complete = 1'b0;
			if (complete) ready_rows = {ready_rows, i};
		end
		if (ready_rows.size() != 0 && $urandom_range(0, 3) != 0)
			r = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
		else
			r = $urandom_range(0, ALPHABET_SIZE - 1);
		for (int unsigned j = 0; j < ALPHABET_SIZE; j++)
			if (!loaded[r][j]) load_entry(DIGIT_BITS'(r), DIGIT_BITS'(j), ENTRY_BITS'($urandom));
		send_item(OP_PUSH, DIGIT_BITS'(r), DIGIT_BITS'($urandom), ENTRY_BITS'($urandom));
	endtask

	// Mostly requests after pushes, some loads that rewrite scores mid-scan,
	// and a little noise that the block only acknowledges.
	task automatic random_item();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 8) begin
			case ($urandom_range(0, 3))
				0: send_item(OP_SPARE, DIGIT_BITS'($urandom), DIGIT_BITS'($urandom),
					ENTRY_BITS'($urandom));
				1: send_item(OP_LOAD, DIGIT_BITS'($urandom_range(20, 31)),
					DIGIT_BITS'($urandom), ENTRY_BITS'($urandom));
				2: send_item(OP_LOAD, DIGIT_BITS'($urandom),
					DIGIT_BITS'($urandom_range(20, 31)), ENTRY_BITS'($urandom));
				default: send_item(OP_PUSH, DIGIT_BITS'($urandom_range(20, 31)),
					DIGIT_BITS'($urandom), ENTRY_BITS'($urandom));
			endcase
		end else if (p < 30) begin
			push_residue();
		end else if (p < 37) begin
			load_entry(DIGIT_BITS'($urandom_range(0, ALPHABET_SIZE - 1)),
				DIGIT_BITS'($urandom_range(0, ALPHABET_SIZE - 1)), ENTRY_BITS'($urandom));
		end else begin
			send_item(OP_NEXT, DIGIT_BITS'($urandom), DIGIT_BITS'($urandom),
				ENTRY_BITS'($urandom));
		end
	endtask

	// Drop valid and hold off until every owed result has arrived.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.awaited.size() != 0);
	endtask

	// Setup cycle, then access cycle; idle after release before returning so the
	// next write does not drive psel twice in one step.
	task automatic apb_write(input logic [PADDR_BITS-1:0] addr,
			input logic [PDATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned start;
		in_valid = 1'b0;
		opcode = OP_LOAD;
		residue_a = '0;
		residue_b = '0;
		entry_score = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset configuration: request on an empty
		// window, the spare opcode, out-of-range loads and pushes (ignored),
		// and the score extremes in the corner entries.
		send_item(OP_NEXT, 5'd0, 5'd0, ENTRY_MAX);
		send_item(OP_SPARE, 5'd31, 5'd31, ENTRY_MIN);
		send_item(OP_LOAD, 5'd31, 5'd0, ENTRY_MAX);
		send_item(OP_LOAD, 5'd0, 5'd31, ENTRY_MIN);
		send_item(OP_LOAD, 5'd20, 5'd19, ENTRY_MAX);
		send_item(OP_LOAD, 5'd19, 5'd20, ENTRY_MIN);
		send_item(OP_PUSH, 5'd31, 5'd31, ENTRY_MIN);
		send_item(OP_PUSH, 5'd20, 5'd0, ENTRY_MAX);
		send_item(OP_NEXT, 5'd19, 5'd19, ENTRY_MIN);
		load_entry(5'd0, 5'd0, ENTRY_MIN);
		load_entry(5'd19, 5'd19, ENTRY_MAX);
		load_entry(5'd0, 5'd19, ENTRY_MAX);
		load_entry(5'd19, 5'd0, ENTRY_MIN);
		send_item(OP_SPARE, 5'd0, 5'd0, '0);
		send_item(OP_NEXT, 5'd31, 5'd0, '0);

		// Random phases. Reconfigure only once the block has drained; the scan
		// position carries across phases, so word length changes mid-scan.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_for_results();
			apb_write(ADDR_WORD_LENGTH, PDATA_BITS'(LEN_BITS'(phase_len[ph])));
			apb_write(ADDR_THRESHOLD, PDATA_BITS'(THR_BITS'(phase_thr[ph])));
			sb.word_len = LEN_BITS'(phase_len[ph]);
			sb.threshold = THR_BITS'(phase_thr[ph]);
			if (ph == HOLD_PHASE) hold_off_req = 1'b1;
			if (ph == NUM_PHASES - 1) no_idling = 1'b1;
			start = items_sent;
			while (items_sent - start < phase_items[ph]) random_item();
		end

		// Drain, then give a stray late result time to show up.
		wait_for_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pwn_pkg.sv
hw/rtl/pwn_cfg_regs.sv
hw/rtl/protein_word_neighborhood.sv
tb/protein_word_neighborhood_test.sv
